// ===== rtl/lld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_pkg
// Shared types and constants for the least-loaded dispatcher.
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int LOAD_W = 48;
  localparam int FAC_W  = 16;
  localparam int AMT_W  = 16;
  localparam int SEL_W  = 4;
  localparam int OP_W   = 2;
  localparam int NUM_W  = 5;
  localparam int PROD_W = FAC_W + AMT_W;

  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // Candidate travelling down the cell chain.
  typedef struct packed {
    logic              tok;
    logic              found;
    logic [LOAD_W-1:0] load;
    logic [FAC_W-1:0]  factor;
  } cand_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              clr;
    logic              fac_we;
    logic [SEL_W-1:0]  fac_sel;
    logic [FAC_W-1:0]  fac_val;
    logic              load_we;
    logic [LOAD_W-1:0] load_val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/lld_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_cell
// One server: holds its factor and load, and passes the best candidate on.
// ----------------------------------------------------------------------------
module lld_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire lld_pkg::cell_ctrl_t ctrl_i,
  input  wire  [IDX_W-1:0]         wr_idx_i,
  input  wire                      first_i,
  input  wire  [IDX_W-1:0]         target_i,
  input  wire  [CNT_W-1:0]         n_use_i,
  input  wire lld_pkg::cand_t      cand_i,
  input  wire  [IDX_W-1:0]         idx_i,
  output lld_pkg::cand_t           cand_o,
  output logic [IDX_W-1:0]         idx_o
);
  import lld_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
  localparam bit               SEL_OK = (IDX < (1 << SEL_W));
  localparam logic [SEL_W-1:0] MY_SEL = SEL_W'(IDX);

  logic [LOAD_W-1:0] load_q;
  logic [FAC_W-1:0]  factor_q;
  logic              tok_q;
  logic              found_q;
  logic [LOAD_W-1:0] cload_q;
  logic [FAC_W-1:0]  cfac_q;
  logic [IDX_W-1:0]  idx_q;
  logic              in_use;
  logic              take;

  assign in_use = (MY_CNT < n_use_i);

  // strict less-than keeps ties on the lower index
  always_comb begin
    if (first_i) begin
      take = in_use && (target_i == MY_IDX);
    end else begin
      take = in_use && (!cand_i.found || (load_q < cand_i.load));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      tok_q <= cand_i.tok;
      if (ctrl_i.clr) begin
        load_q <= '0;
      end else if (ctrl_i.load_we && (wr_idx_i == MY_IDX)) begin
        load_q <= ctrl_i.load_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (SEL_OK && ctrl_i.fac_we && (ctrl_i.fac_sel == MY_SEL)) begin
      factor_q <= ctrl_i.fac_val;
    end
    if (take) begin
      found_q <= 1'b1;
      cload_q <= load_q;
      cfac_q  <= factor_q;
      idx_q   <= MY_IDX;
    end else begin
      found_q <= cand_i.found;
      cload_q <= cand_i.load;
      cfac_q  <= cand_i.factor;
      idx_q   <= idx_i;
    end
  end

  assign cand_o = '{tok: tok_q, found: found_q, load: cload_q, factor: cfac_q};
  assign idx_o  = idx_q;

endmodule
`default_nettype wire

// ===== rtl/lld_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_mac
// Two-stage multiply-add: load + size * factor, saturating at 48 bits.
// ----------------------------------------------------------------------------
module lld_mac (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       go_i,
  input  wire  [lld_pkg::LOAD_W-1:0] load_i,
  input  wire  [lld_pkg::FAC_W-1:0]  fac_i,
  input  wire  [lld_pkg::AMT_W-1:0]  amt_i,
  output logic                      vld_o,
  output logic [lld_pkg::LOAD_W-1:0] sum_o
);
  import lld_pkg::*;

  logic              vld1_q;
  logic              vld2_q;
  logic [PROD_W-1:0] prod_q;
  logic [LOAD_W-1:0] load1_q;
  logic [LOAD_W-1:0] sum_q;
  logic [LOAD_W:0]   sum_wide;

  assign sum_wide = {1'b0, load1_q} + {{(LOAD_W + 1 - PROD_W){1'b0}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= go_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= PROD_W'(amt_i) * PROD_W'(fac_i);
    load1_q <= load_i;
    sum_q   <= sum_wide[LOAD_W] ? {LOAD_W{1'b1}} : sum_wide[LOAD_W-1:0];
  end

  assign vld_o = vld2_q;
  assign sum_o = sum_q;

endmodule
`default_nettype wire

// ===== rtl/least_loaded_dispatch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_dispatch
// Greedy dispatcher: one job per server in use by index, then least loaded.
// ----------------------------------------------------------------------------
// Input transactions carry the opcode on s_axis_tuser and the server select
// and amount on s_axis_tdata. Every input transaction yields one output
// transaction with chosen server, its new finish time and the makespan.
// cfg_we_i/cfg_wdata_i write the server count; write it only while idle.
//
// Load, clear and no-op pass from idle to the emit state, which moves the
// result into the output register once that register is free.
// A dispatch waits in the busy state: a token walks the chain of server
// cells one cell per cycle to find the minimum load, then a two-stage
// multiply-add updates the chosen server, and the emit state passes on
// its result. One transaction is in flight at a time; a finished
// result waits in the output register while the next input is accepted, and
// a stalled receiver holds the block once that register and the result
// stage are both full.
//
// Reset clears all loads, the first-round counter and the makespan, and
// sets the server count to 1. Factors are unknown until loaded.
// ----------------------------------------------------------------------------
module least_loaded_dispatch #(
  parameter int MAX_SERVERS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [lld_pkg::NUM_W-1:0]    cfg_wdata_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,   // server_sel, amount, pad
  input  wire  [lld_pkg::OP_W-1:0]     s_axis_tuser,   // opcode
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [103:0]                 m_axis_tdata    // chosen_server,
                                                       // server_finish,
                                                       // makespan, pad
);
  import lld_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state_q;
  logic [NUM_W-1:0]  num_q;
  logic [CNT_W-1:0]  n_use;
  logic [CNT_W-1:0]  jobs_q;
  logic [LOAD_W-1:0] max_q;
  logic              first_q;
  logic [IDX_W-1:0]  target_q;
  logic [AMT_W-1:0]  amt_q;
  logic              start_q;
  logic [IDX_W-1:0]  pick_idx_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [LOAD_W-1:0] res_fin_q;
  logic [LOAD_W-1:0] res_mk_q;
  logic              out_vld_q;
  logic [103:0]      out_data_q;

  logic              accept;
  logic [OP_W-1:0]   op;
  logic [SEL_W-1:0]  sel;
  logic [AMT_W-1:0]  amt;
  logic              mac_vld;
  logic [LOAD_W-1:0] mac_sum;
  cell_ctrl_t        ctrl;

  cand_t             chain     [0:MAX_SERVERS];
  logic [IDX_W-1:0]  idx_chain [0:MAX_SERVERS];

  assign accept = s_axis_tvalid && s_axis_tready;
  assign op     = s_axis_tuser;
  assign sel    = s_axis_tdata[3:0];
  assign amt    = s_axis_tdata[19:4];

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    if (num_q == '0) begin
      n_use = CNT_W'(1);
    end else if (int'(num_q) > MAX_SERVERS) begin
      n_use = CNT_W'(MAX_SERVERS);
    end else begin
      n_use = CNT_W'(num_q);
    end
  end

  always_comb begin
    ctrl.clr      = accept && (op == OP_CLEAR);
    ctrl.fac_we   = accept && (op == OP_LOAD);
    ctrl.fac_sel  = sel;
    ctrl.fac_val  = amt;
    ctrl.load_we  = mac_vld;
    ctrl.load_val = mac_sum;
  end

  assign chain[0]     = '{tok: start_q, found: 1'b0, load: '0, factor: '0};
  assign idx_chain[0] = '0;

  for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_cell
    lld_cell #(
      .IDX   (k),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_idx_i (pick_idx_q),
      .first_i  (first_q),
      .target_i (target_q),
      .n_use_i  (n_use),
      .cand_i   (chain[k]),
      .idx_i    (idx_chain[k]),
      .cand_o   (chain[k+1]),
      .idx_o    (idx_chain[k+1])
    );
  end

  lld_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (chain[MAX_SERVERS].tok),
    .load_i (chain[MAX_SERVERS].load),
    .fac_i  (chain[MAX_SERVERS].factor),
    .amt_i  (amt_q),
    .vld_o  (mac_vld),
    .sum_o  (mac_sum)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      num_q     <= NUM_W'(1);
      jobs_q    <= '0;
      max_q     <= '0;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      start_q <= accept && (op == OP_DISPATCH);
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if ((state_q == S_EMIT) && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_DISPATCH) begin
              state_q <= S_BUSY;
              if (jobs_q < n_use) begin
                jobs_q <= jobs_q + CNT_W'(1);
              end
            end else begin
              state_q <= S_EMIT;
              if (op == OP_CLEAR) begin
                jobs_q <= '0;
                max_q  <= '0;
              end
            end
          end
        end
        S_BUSY: begin
          if (mac_vld) begin
            state_q <= S_EMIT;
            if (mac_sum > max_q) begin
              max_q <= mac_sum;
            end
          end
        end
        S_EMIT: begin
          if (!out_vld_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      amt_q     <= amt;
      first_q   <= (jobs_q < n_use);
      target_q  <= jobs_q[IDX_W-1:0];
      res_idx_q <= '0;
      res_fin_q <= '0;
      res_mk_q  <= (op == OP_CLEAR) ? '0 : max_q;
    end
    if (chain[MAX_SERVERS].tok) begin
      pick_idx_q <= idx_chain[MAX_SERVERS];
    end
    if (mac_vld) begin
      res_idx_q <= pick_idx_q;
      res_fin_q <= mac_sum;
      res_mk_q  <= (mac_sum > max_q) ? mac_sum : max_q;
    end
    if ((state_q == S_EMIT) && (!out_vld_q || m_axis_tready)) begin
      out_data_q <= {4'b0, res_mk_q, res_fin_q, 4'(res_idx_q)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_mac_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_vld |-> (state_q == S_BUSY))
    else $error("multiply-add result outside a dispatch");

  a_chain_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_SERVERS].tok |-> chain[MAX_SERVERS].found)
    else $error("search token left the chain without a server");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_CLEAR)) |=> ((max_q == '0) && (jobs_q == '0)))
    else $error("clear did not reset makespan and job count");

  a_makespan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_vld |=> (max_q >= $past(mac_sum)))
    else $error("makespan below a finish time");

endmodule
`default_nettype wire

// ===== test/tb_least_loaded_dispatch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_loaded_dispatch
// Self-checking bench for the greedy least-loaded job dispatcher.
// ----------------------------------------------------------------------------
// A dispatch model inside a small scoreboard class tracks factors, loads, the
// first-round count and the makespan, and predicts one result per accepted
// input transaction. A directed opening loads every factor and hits the
// extreme values. Random phases follow under several server counts, with
// bursty input and a receiver that stalls on patterns of its own. A short
// final run of maximal jobs on one server exercises the widest products.
// ----------------------------------------------------------------------------
module tb_least_loaded_dispatch;
  import lld_pkg::*;

  localparam int MAX_SERVERS = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 100;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  // Server counts for the random phases: in range, zero and above the top.
  localparam logic [NUM_W-1:0] COUNT_PLAN [11] = '{
    5'd16, 5'd0, 5'd31, 5'd1, 5'd4, 5'd17, 5'd2, 5'd16, 5'd9, 5'd3, 5'd16
  };
  localparam int ITEMS_PER_PHASE = 48;
  // 65535 * 65535 per job on a single server
  localparam int HEAVY_JOBS = 12;

  typedef struct {
    logic [SEL_W-1:0]  server;
    logic [LOAD_W-1:0] finish;
    logic [LOAD_W-1:0] makespan;
  } dispatch_result_t;

  class dispatch_scoreboard;
    logic [FAC_W-1:0]  factor [MAX_SERVERS];
    logic [LOAD_W-1:0] load [MAX_SERVERS];
    int unsigned       placed;
    logic [LOAD_W-1:0] max_finish;
    logic [NUM_W-1:0]  server_count;
    dispatch_result_t  expected_q [$];
    int unsigned       errors;

    function new();
      foreach (factor[i]) factor[i] = '0;
      foreach (load[i]) load[i] = '0;
      placed = 0;
      max_finish = '0;
      server_count = 5'd1;
      errors = 0;
    endfunction

    function void set_server_count(logic [NUM_W-1:0] value);
      server_count = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update the dispatch state for one input transaction, queue its result.
    function void note_input(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                             logic [AMT_W-1:0] amt);
      dispatch_result_t r;
      int unsigned in_use;
      int unsigned pick;
      int unsigned i;
      logic [63:0] sum;
      r.server = '0;
      r.finish = '0;
      if (op == OP_LOAD) begin
        if (sel < MAX_SERVERS) factor[sel] = amt;
      end else if (op == OP_DISPATCH) begin
        in_use = (server_count == 0) ? 1 :
                 ((server_count > MAX_SERVERS) ? MAX_SERVERS : server_count);
        if (placed < in_use) begin
          pick = placed;
          placed++;
        end else begin
          pick = 0;
          for (i = 1; i < in_use; i++)
            if (load[i] < load[pick]) pick = i;
        end
        sum = {16'b0, load[pick]} + 64'(amt) * 64'(factor[pick]);
        if (sum > {16'b0, LOAD_MAX}) sum = {16'b0, LOAD_MAX};
        load[pick] = sum[LOAD_W-1:0];
        if (load[pick] > max_finish) max_finish = load[pick];
        r.server = pick[SEL_W-1:0];
        r.finish = load[pick];
      end else if (op == OP_CLEAR) begin
        foreach (load[k]) load[k] = '0;
        placed = 0;
        max_finish = '0;
      end
      r.makespan = max_finish;
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [LOAD_W-1:0] exp_v,
                         logic [LOAD_W-1:0] act_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v,
                 act_v);
    endfunction

    function void check_result(logic [103:0] data);
      dispatch_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual 0x%h", $time, data);
        return;
      end
      e = expected_q.pop_front();
      if (data[3:0] !== e.server) report("chosen_server", 48'(e.server), 48'(data[3:0]));
      if (data[51:4] !== e.finish) report("server_finish", e.finish, data[51:4]);
      if (data[99:52] !== e.makespan) report("makespan", e.makespan, data[99:52]);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [NUM_W-1:0]   cfg_wdata = '0;
  logic               s_valid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_data = '0;
  logic [OP_W-1:0]    s_user = '0;
  logic               m_axis_tvalid;
  logic               m_ready = 1'b0;
  logic [103:0]       m_axis_tdata;

  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;
  int unsigned        hold_cnt = 0;
  int unsigned        rx_cycle = 0;
  int unsigned        rx_mode = 0;
  int unsigned        idle_cycles = 0;
  bit                 gaps_on = 1'b1;

  dispatch_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  least_loaded_dispatch #(
    .MAX_SERVERS(MAX_SERVERS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Check results first, then record the input accepted at the same edge.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata);
    if (s_valid && s_axis_tready) sb.note_input(s_user, s_data[3:0], s_data[19:4]);
  end

  // Receiver: switches among stall patterns at random, long hold on request.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      m_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= 1'($urandom_range(0, 1));
        2: m_ready <= (rx_cycle % 7) < 3;
        default: m_ready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one transaction and return at the edge where it is accepted.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                           input logic [AMT_W-1:0] amt);
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {4'b0, amt, sel};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_server_count(input logic [NUM_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    sb.set_server_count(value);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item(output logic [OP_W-1:0] op, output logic [SEL_W-1:0] sel,
                             output logic [AMT_W-1:0] amt);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 72) op = OP_DISPATCH;
    else if (roll < 90) op = OP_LOAD;
    else if (roll < 94) op = OP_CLEAR;
    else op = OP_NOP;
    sel = SEL_W'($urandom_range(0, 15));
    // small values make ties between servers likely
    roll = $urandom_range(0, 99);
    if (roll < 25) amt = AMT_W'($urandom_range(0, 3));
    else if (roll < 35) amt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else amt = AMT_W'($urandom_range(0, 65535));
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned burst;
    int unsigned n;
    logic [OP_W-1:0] op;
    logic [SEL_W-1:0] sel;
    logic [AMT_W-1:0] amt;
    burst = 0;
    for (n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        if (gaps_on && n != 0) begin
          s_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      random_item(op, sel, amt);
      send_item(op, sel, amt);
      burst--;
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned s;
    rst_n = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed opening: every factor loaded before any dispatch can read it.
    send_item(OP_NOP, 4'hF, 16'hFFFF);
    for (s = 0; s < MAX_SERVERS; s++) begin
      case (s)
        0: send_item(OP_LOAD, 4'(s), 16'hFFFF);
        1: send_item(OP_LOAD, 4'(s), 16'h0000);
        2: send_item(OP_LOAD, 4'(s), 16'h0001);
        default: send_item(OP_LOAD, 4'(s), 16'($urandom_range(0, 65535)));
      endcase
    end
    send_item(OP_DISPATCH, 4'h0, 16'hFFFF);
    send_item(OP_DISPATCH, 4'hF, 16'h0000);
    send_item(OP_DISPATCH, 4'h5, 16'h0001);
    send_item(OP_CLEAR, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    send_item(OP_NOP, 4'h0, 16'h0000);
    send_item(OP_DISPATCH, 4'hA, 16'h0002);

    for (p = 0; p < $size(COUNT_PLAN); p++) begin
      write_server_count(COUNT_PLAN[p]);
      gaps_on = (p % 4) != 3;
      if (p == 2) begin
        // receiver holds off while the sender keeps offering back to back
        hold_req <= 1'b1;
        gaps_on = 1'b0;
        send_random(12);
        gaps_on = 1'b1;
        send_random(ITEMS_PER_PHASE - 12);
      end else if (p == 5) begin
        send_random(ITEMS_PER_PHASE / 2);
        wait_drained();
        send_random(ITEMS_PER_PHASE / 2);
      end else begin
        send_random(ITEMS_PER_PHASE);
      end
    end

    // Maximal jobs on a single server: widest products into one load.
    write_server_count(5'd1);
    send_item(OP_CLEAR, 4'h0, 16'h0000);
    send_item(OP_LOAD, 4'h0, 16'hFFFF);
    for (s = 0; s < HEAVY_JOBS; s++)
      send_item(OP_DISPATCH, 4'(s), 16'hFFFF);
    send_item(OP_NOP, 4'h3, 16'h1234);

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
